/* rtl/bt_pkg.sv */
`default_nettype none

package bt_pkg;

    localparam int SQ_STEPS  = 32;
    localparam int DIV_STEPS = 33;
    // squares, sum, root steps, divide setup, divide steps, round
    localparam int NORM_LAT  = 1 + 1 + SQ_STEPS + 1 + DIV_STEPS + 1;

    typedef logic signed [31:0] t_q30;
    typedef t_q30 t_quat [4];
    typedef logic signed [33:0] t_mq;
    typedef t_mq t_prod [16];

    localparam t_q30 Q30_ONE = 32'sh4000_0000;
    localparam t_q30 Q30_MAX = 32'sh7fff_ffff;
    localparam t_q30 Q30_MIN = 32'sh8000_0000;

    typedef struct packed {
        t_q30 cur_w;
        t_q30 cur_x;
        t_q30 cur_y;
        t_q30 cur_z;
        t_q30 next_w;
        t_q30 next_x;
        t_q30 next_y;
        t_q30 next_z;
    } t_in_s;

    typedef struct packed {
        t_q30 proj_cur_w;
        t_q30 proj_cur_x;
        t_q30 proj_cur_y;
        t_q30 proj_cur_z;
        t_q30 proj_next_w;
        t_q30 proj_next_x;
        t_q30 proj_next_y;
        t_q30 proj_next_z;
    } t_out_s;

    typedef enum logic [2:0] {
        DRV_IDLE,
        DRV_MUL,
        DRV_SUM,
        DRV_SQ,
        DRV_NSUM,
        DRV_LOAD,
        DRV_DIV
    } t_drv_state;

    // Q2.30 x Q2.30 product in Q4.30, round half up
    function automatic t_mq mq(input t_q30 a, input t_q30 b);
        logic signed [63:0] p;
        p = 64'(a) * 64'(b) + 64'sd536870912;
        return p[63:30];
    endfunction

    function automatic t_q30 sat36(input logic signed [35:0] s);
        t_q30 r;
        if (s > 36'sd2147483647) begin
            r = Q30_MAX;
        end else if (s < -36'sd2147483648) begin
            r = Q30_MIN;
        end else begin
            r = s[31:0];
        end
        return r;
    endfunction

    function automatic t_q30 neg_sat(input t_q30 x);
        return (x == Q30_MIN) ? Q30_MAX : -x;
    endfunction

    function automatic t_quat conj(input t_quat a);
        t_quat r;
        r[0] = a[0];
        r[1] = neg_sat(a[1]);
        r[2] = neg_sat(a[2]);
        r[3] = neg_sat(a[3]);
        return r;
    endfunction

    // all 16 rounded cross products, p[i*4+j] = a[i]*b[j]
    function automatic t_prod qm_prod(input t_quat a, input t_quat b);
        t_prod p;
        for (int i = 0; i < 4; i++) begin
            for (int j = 0; j < 4; j++) begin
                p[i*4+j] = mq(a[i], b[j]);
            end
        end
        return p;
    endfunction

    function automatic t_quat qm_sum(input t_prod p);
        t_quat r;
        r[0] = sat36(36'(p[0]) - 36'(p[5])  - 36'(p[10]) - 36'(p[15]));
        r[1] = sat36(36'(p[1]) + 36'(p[4])  + 36'(p[11]) - 36'(p[14]));
        r[2] = sat36(36'(p[2]) - 36'(p[7])  + 36'(p[8])  + 36'(p[13]));
        r[3] = sat36(36'(p[3]) + 36'(p[6])  - 36'(p[9])  + 36'(p[12]));
        return r;
    endfunction

    function automatic t_quat in_q(input t_in_s d);
        t_quat r;
        r[0] = d.cur_w;
        r[1] = d.cur_x;
        r[2] = d.cur_y;
        r[3] = d.cur_z;
        return r;
    endfunction

    function automatic t_quat in_u(input t_in_s d);
        t_quat r;
        r[0] = d.next_w;
        r[1] = d.next_x;
        r[2] = d.next_y;
        r[3] = d.next_z;
        return r;
    endfunction

endpackage

`default_nettype wire

/* rtl/bt_norm.sv */
`default_nettype none

// Pipelined quaternion normalize: bit-serial root, then four restoring dividers.
module bt_norm
    import bt_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_en,
    input  t_quat i_quat,
    output t_quat o_quat
);

    localparam int DV_N = DIV_STEPS + 1;

    t_quat       r_s0_c;
    logic [60:0] r_s0_sq [4];
    t_quat       r_s1_c;
    logic [62:0] r_s1_s;

    logic [63:0] r_rt_s    [SQ_STEPS];
    logic [33:0] r_rt_rem  [SQ_STEPS];
    logic [31:0] r_rt_root [SQ_STEPS];
    t_quat       r_rt_c    [SQ_STEPS];
    logic [63:0] n_rt_s    [SQ_STEPS];
    logic [33:0] n_rt_rem  [SQ_STEPS];
    logic [31:0] n_rt_root [SQ_STEPS];
    t_quat       n_rt_c    [SQ_STEPS];

    logic [31:0] r_dv_r   [DV_N];
    t_quat       r_dv_c   [DV_N];
    logic [31:0] r_dv_mag [DV_N][4];
    logic [31:0] r_dv_rem [DV_N][4];
    logic [32:0] r_dv_q   [DV_N][4];
    logic        r_dv_ovf [DV_N][4];
    logic [31:0] n_dv_r   [DV_N];
    t_quat       n_dv_c   [DV_N];
    logic [31:0] n_dv_mag [DV_N][4];
    logic [31:0] n_dv_rem [DV_N][4];
    logic [32:0] n_dv_q   [DV_N][4];
    logic        n_dv_ovf [DV_N][4];

    t_quat       r_fin;
    t_quat       n_fin;
    logic [60:0] n_s0_sq [4];
    logic [62:0] n_s1_s;

    // squares and their sum
    always_comb begin
        logic signed [63:0] sqv;
        for (int i = 0; i < 4; i++) begin
            sqv = 64'(i_quat[i]) * 64'(i_quat[i]);
            n_s0_sq[i] = sqv[62:2];
        end
        n_s1_s = 63'(r_s0_sq[0]) + 63'(r_s0_sq[1]) + 63'(r_s0_sq[2]) + 63'(r_s0_sq[3]);
    end

    // one root digit per stage
    always_comb begin
        logic [63:0] s_prev;
        logic [33:0] rem_prev;
        logic [31:0] root_prev;
        logic [35:0] rem2;
        logic [35:0] trial;
        for (int k = 0; k < SQ_STEPS; k++) begin
            if (k == 0) begin
                s_prev    = {1'b0, r_s1_s};
                rem_prev  = '0;
                root_prev = '0;
                n_rt_c[k] = r_s1_c;
            end else begin
                s_prev    = r_rt_s[k-1];
                rem_prev  = r_rt_rem[k-1];
                root_prev = r_rt_root[k-1];
                n_rt_c[k] = r_rt_c[k-1];
            end
            rem2  = {rem_prev, s_prev[63-2*k -: 2]};
            trial = {2'b00, root_prev, 2'b01};
            if (rem2 >= trial) begin
                n_rt_rem[k]  = 34'(rem2 - trial);
                n_rt_root[k] = {root_prev[30:0], 1'b1};
            end else begin
                n_rt_rem[k]  = rem2[33:0];
                n_rt_root[k] = {root_prev[30:0], 1'b0};
            end
            n_rt_s[k] = s_prev;
        end
    end

    // divide setup, then one quotient bit per stage
    always_comb begin
        logic [31:0] rr;
        logic [31:0] mag;
        logic        dbit;
        logic [32:0] rem2;
        int          j;
        rr = r_rt_root[SQ_STEPS-1];
        n_dv_r[0] = rr;
        n_dv_c[0] = r_rt_c[SQ_STEPS-1];
        for (int i = 0; i < 4; i++) begin
            mag = r_rt_c[SQ_STEPS-1][i][31] ? 32'(-r_rt_c[SQ_STEPS-1][i])
                                            : 32'(r_rt_c[SQ_STEPS-1][i]);
            n_dv_mag[0][i] = mag;
            n_dv_ovf[0][i] = {3'b000, mag} >= {rr, 3'b000};
            n_dv_rem[0][i] = {3'b000, mag[31:3]};
            n_dv_q[0][i]   = '0;
        end
        for (int k = 1; k < DV_N; k++) begin
            j = DV_N - 1 - k;
            n_dv_r[k] = r_dv_r[k-1];
            n_dv_c[k] = r_dv_c[k-1];
            for (int i = 0; i < 4; i++) begin
                dbit = (j >= 30) ? r_dv_mag[k-1][i][5'(j - 30)] : 1'b0;
                rem2 = {r_dv_rem[k-1][i], dbit};
                n_dv_mag[k][i] = r_dv_mag[k-1][i];
                n_dv_ovf[k][i] = r_dv_ovf[k-1][i];
                if (rem2 >= {1'b0, r_dv_r[k-1]}) begin
                    n_dv_rem[k][i] = 32'(rem2 - {1'b0, r_dv_r[k-1]});
                    n_dv_q[k][i]   = {r_dv_q[k-1][i][31:0], 1'b1};
                end else begin
                    n_dv_rem[k][i] = rem2[31:0];
                    n_dv_q[k][i]   = {r_dv_q[k-1][i][31:0], 1'b0};
                end
            end
        end
    end

    // round half away from zero and saturate
    always_comb begin
        logic [33:0] qr;
        logic        neg;
        for (int i = 0; i < 4; i++) begin
            qr  = (34'(r_dv_q[DV_N-1][i]) + 34'd1) >> 1;
            neg = r_dv_c[DV_N-1][i][31];
            if (r_dv_r[DV_N-1] == '0) begin
                n_fin[i] = r_dv_c[DV_N-1][i];
            end else if (r_dv_ovf[DV_N-1][i]) begin
                n_fin[i] = neg ? Q30_MIN : Q30_MAX;
            end else if (!neg) begin
                n_fin[i] = (qr > 34'd2147483647) ? Q30_MAX : qr[31:0];
            end else begin
                n_fin[i] = (qr > 34'd2147483648) ? Q30_MIN : -qr[31:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s0_c  <= i_quat;
            r_s0_sq <= n_s0_sq;
            r_s1_c  <= r_s0_c;
            r_s1_s  <= n_s1_s;
            r_rt_s    <= n_rt_s;
            r_rt_rem  <= n_rt_rem;
            r_rt_root <= n_rt_root;
            r_rt_c    <= n_rt_c;
            r_dv_r   <= n_dv_r;
            r_dv_c   <= n_dv_c;
            r_dv_mag <= n_dv_mag;
            r_dv_rem <= n_dv_rem;
            r_dv_q   <= n_dv_q;
            r_dv_ovf <= n_dv_ovf;
            r_fin    <= n_fin;
        end
    end

    assign o_quat = r_fin;

endmodule

`default_nettype wire

/* rtl/bend_twist_projection.sv */
// Pipeline: 145 register stages from the request accept edge to o_valid:
//   4 multiply stages, 69-stage normalize, 2 multiply stages, 69-stage normalize,
//   output register.
// Throughput: one request per cycle while o_stall is low; an output register plus skid
//   stage keeps the input open while one result waits, and a full skid stalls it.
// A config write stalls the input in its access cycle and then while a serial divider
//   recomputes the inverse rest Darboux quaternion (the divider is skipped at zero norm).
// Reset (i_rst_n, synchronous, active low): pipeline empty, rest orientations identity.
`default_nettype none

module bend_twist_projection
    import bt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request channel
    input  logic        i_valid,
    input  t_in_s       i_data,
    output logic        o_stall,
    // result channel
    output logic        o_valid,
    output t_out_s      o_data,
    input  logic        i_stall,
    // config port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int DV_BITS = 62;

    //------------------------------------------------------------------
    // Config registers: rest_cur (q0) at 0..3, rest_next (u0) at 4..7
    //------------------------------------------------------------------
    t_q30 r_cfg [8];
    logic cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = 32'(r_cfg[paddr[4:2]]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 8; i++) begin
                r_cfg[i] <= ((i == 0) || (i == 4)) ? Q30_ONE : '0;
            end
        end else if (cfg_wr) begin
            r_cfg[paddr[4:2]] <= pwdata;
        end
    end

    //------------------------------------------------------------------
    // Inverse rest Darboux quaternion, D = conj(q0)*u0, inv = conj(D)/|D|^2.
    // Sequenced: products, sum, squares, norm sum, then one shared
    // restoring divider, one quotient bit per cycle for each component.
    //------------------------------------------------------------------
    t_drv_state r_drv_state, n_drv_state;
    t_prod       r_dprod;
    t_quat       r_dar;
    t_mq         r_dsq [4];
    logic [34:0] r_n;
    t_quat       r_idar;
    logic [1:0]  r_dv_idx;
    logic [5:0]  r_dv_cnt;
    logic [61:0] r_dv_num;
    logic [34:0] r_dv_rem;
    logic [61:0] r_dv_quo;
    logic        r_dv_neg;

    t_quat       w_q0;
    t_quat       w_u0;
    t_q30        w_ld_d;
    logic [31:0] w_ld_mag;
    logic [61:0] w_ld_num;
    logic        w_ld_neg;
    logic [35:0] w_dv_rem2;
    logic        w_dv_ge;
    logic [61:0] w_dv_q;
    t_q30        w_dv_res;
    logic        dv_last;

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            w_q0[i] = r_cfg[i];
            w_u0[i] = r_cfg[4+i];
        end
    end

    // dividend = |D_i| * 2^30 + n/2; sign from the conjugate
    assign w_ld_d   = r_dar[r_dv_idx];
    assign w_ld_mag = w_ld_d[31] ? 32'(-w_ld_d) : 32'(w_ld_d);
    assign w_ld_num = {w_ld_mag, 30'b0} + 62'(r_n >> 1);
    assign w_ld_neg = (r_dv_idx == 2'd0) ? w_ld_d[31] : (!w_ld_d[31] && (w_ld_d != '0));

    assign w_dv_rem2 = {r_dv_rem, r_dv_num[61]};
    assign w_dv_ge   = w_dv_rem2 >= {1'b0, r_n};
    assign w_dv_q    = {r_dv_quo[60:0], w_dv_ge};
    assign dv_last   = (r_dv_cnt == 6'(DV_BITS - 1));

    always_comb begin
        if (!r_dv_neg) begin
            w_dv_res = (w_dv_q > 62'd2147483647) ? Q30_MAX : w_dv_q[31:0];
        end else begin
            w_dv_res = (w_dv_q > 62'd2147483648) ? Q30_MIN : -w_dv_q[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_drv_state <= DRV_IDLE;
        end else begin
            r_drv_state <= n_drv_state;
        end
    end

    always_comb begin
        n_drv_state = r_drv_state;
        priority if (cfg_wr) begin
            n_drv_state = DRV_MUL;
        end else begin
            unique case (r_drv_state)
                DRV_IDLE: n_drv_state = DRV_IDLE;
                DRV_MUL:  n_drv_state = DRV_SUM;
                DRV_SUM:  n_drv_state = DRV_SQ;
                DRV_SQ:   n_drv_state = DRV_NSUM;
                DRV_NSUM: n_drv_state = DRV_LOAD;
                DRV_LOAD: n_drv_state = (r_n == '0) ? DRV_IDLE : DRV_DIV;
                DRV_DIV: begin
                    if (dv_last) begin
                        n_drv_state = (r_dv_idx == 2'd3) ? DRV_IDLE : DRV_LOAD;
                    end
                end
                default:  n_drv_state = DRV_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idar[0] <= Q30_ONE;
            r_idar[1] <= '0;
            r_idar[2] <= '0;
            r_idar[3] <= '0;
            r_dv_idx  <= '0;
            r_dv_cnt  <= '0;
        end else begin
            unique case (r_drv_state)
                DRV_NSUM: r_dv_idx <= '0;
                DRV_LOAD: begin
                    r_dv_cnt <= '0;
                    if (r_n == '0) begin
                        for (int i = 0; i < 4; i++) begin
                            r_idar[i] <= '0;
                        end
                    end
                end
                DRV_DIV: begin
                    r_dv_cnt <= r_dv_cnt + 6'd1;
                    if (dv_last) begin
                        r_idar[r_dv_idx] <= w_dv_res;
                        r_dv_idx <= r_dv_idx + 2'd1;
                    end
                end
                default: ;
            endcase
        end
    end

    // divider payload
    always_ff @(posedge i_clk) begin
        unique case (r_drv_state)
            DRV_MUL:  r_dprod <= qm_prod(conj(w_q0), w_u0);
            DRV_SUM:  r_dar   <= qm_sum(r_dprod);
            DRV_SQ: begin
                for (int i = 0; i < 4; i++) begin
                    r_dsq[i] <= mq(r_dar[i], r_dar[i]);
                end
            end
            DRV_NSUM: r_n <= 35'(r_dsq[0][32:0]) + 35'(r_dsq[1][32:0])
                           + 35'(r_dsq[2][32:0]) + 35'(r_dsq[3][32:0]);
            DRV_LOAD: begin
                r_dv_num <= w_ld_num;
                r_dv_neg <= w_ld_neg;
                r_dv_rem <= '0;
                r_dv_quo <= '0;
            end
            DRV_DIV: begin
                r_dv_num <= {r_dv_num[60:0], 1'b0};
                r_dv_rem <= w_dv_ge ? 35'(w_dv_rem2 - {1'b0, r_n}) : w_dv_rem2[34:0];
                r_dv_quo <= w_dv_q;
            end
            default: ;
        endcase
    end

    //------------------------------------------------------------------
    // Main pipeline, one global enable; it freezes only when the skid
    // stage holds a result.
    //   P1  products inv(D) x conj(q)
    //   P2  sum -> t1
    //   P3  products t1 x u
    //   P4  sum -> T, pre = (1, round(vec(T)/2))
    //   W   normalize pre (NORM_LAT stages), q/u ride along
    //   P5  products q x W and u x conj(W)
    //   P6  sums
    //   O   normalize both (NORM_LAT stages)
    //------------------------------------------------------------------
    logic   en;
    logic   in_acc;

    logic   r_p1_v, r_p2_v, r_p3_v, r_p4_v, r_p5_v, r_p6_v;
    t_prod  r_p1_prod, r_p3_prod;
    t_quat  r_p2_t1, r_p4_pre;
    t_in_s  r_p1_in, r_p2_in, r_p3_in, r_p4_in;
    logic   r_wv [NORM_LAT];
    t_in_s  r_win [NORM_LAT];
    t_prod  r_p5_qp, r_p5_up;
    t_quat  r_p6_qs, r_p6_us;
    logic   r_ov [NORM_LAT];

    t_quat  n_p4_pre;
    t_quat  w_wq;
    t_quat  w_oq;
    t_quat  w_ou;
    t_out_s w_last;

    // output register and skid stage
    logic   r_out_vld;
    logic   r_skid_vld;
    t_out_s r_out;
    t_out_s r_skid;
    logic   out_take;
    logic   last_v;

    assign en      = !r_skid_vld;
    assign o_stall = !en || (r_drv_state != DRV_IDLE) || cfg_wr;
    assign in_acc  = i_valid && !o_stall;

    always_comb begin
        t_quat t;
        t = qm_sum(r_p3_prod);
        n_p4_pre[0] = Q30_ONE;
        for (int i = 1; i < 4; i++) begin
            n_p4_pre[i] = 32'((33'(t[i]) + 33'sd1) >>> 1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_v <= 1'b0;
            r_p2_v <= 1'b0;
            r_p3_v <= 1'b0;
            r_p4_v <= 1'b0;
            r_p5_v <= 1'b0;
            r_p6_v <= 1'b0;
            for (int k = 0; k < NORM_LAT; k++) begin
                r_wv[k] <= 1'b0;
                r_ov[k] <= 1'b0;
            end
        end else if (en) begin
            r_p1_v <= in_acc;
            r_p2_v <= r_p1_v;
            r_p3_v <= r_p2_v;
            r_p4_v <= r_p3_v;
            r_wv[0] <= r_p4_v;
            for (int k = 1; k < NORM_LAT; k++) begin
                r_wv[k] <= r_wv[k-1];
                r_ov[k] <= r_ov[k-1];
            end
            r_p5_v  <= r_wv[NORM_LAT-1];
            r_p6_v  <= r_p5_v;
            r_ov[0] <= r_p6_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p1_prod <= qm_prod(r_idar, conj(in_q(i_data)));
            r_p1_in   <= i_data;
            r_p2_t1   <= qm_sum(r_p1_prod);
            r_p2_in   <= r_p1_in;
            r_p3_prod <= qm_prod(r_p2_t1, in_u(r_p2_in));
            r_p3_in   <= r_p2_in;
            r_p4_pre  <= n_p4_pre;
            r_p4_in   <= r_p3_in;
            r_win[0]  <= r_p4_in;
            for (int k = 1; k < NORM_LAT; k++) begin
                r_win[k] <= r_win[k-1];
            end
            r_p5_qp <= qm_prod(in_q(r_win[NORM_LAT-1]), w_wq);
            r_p5_up <= qm_prod(in_u(r_win[NORM_LAT-1]), conj(w_wq));
            r_p6_qs <= qm_sum(r_p5_qp);
            r_p6_us <= qm_sum(r_p5_up);
        end
    end

    bt_norm u_norm_w (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_quat (r_p4_pre),
        .o_quat (w_wq)
    );

    bt_norm u_norm_q (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_quat (r_p6_qs),
        .o_quat (w_oq)
    );

    bt_norm u_norm_u (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_quat (r_p6_us),
        .o_quat (w_ou)
    );

    assign w_last = '{proj_cur_w:  w_oq[0], proj_cur_x:  w_oq[1],
                      proj_cur_y:  w_oq[2], proj_cur_z:  w_oq[3],
                      proj_next_w: w_ou[0], proj_next_x: w_ou[1],
                      proj_next_y: w_ou[2], proj_next_z: w_ou[3]};

    //------------------------------------------------------------------
    // Output register and skid stage. The skid only fills while the
    // output is stalled; a full skid freezes the pipeline next cycle.
    //------------------------------------------------------------------
    assign out_take = r_out_vld && !i_stall;
    assign last_v   = en && r_ov[NORM_LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else begin
            priority if (last_v) begin
                if (!r_out_vld || out_take) begin
                    r_out_vld <= 1'b1;
                end else begin
                    r_skid_vld <= 1'b1;
                end
            end else if (r_skid_vld && out_take) begin
                r_skid_vld <= 1'b0;
            end else if (out_take) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        priority if (last_v) begin
            if (!r_out_vld || out_take) begin
                r_out <= w_last;
            end else begin
                r_skid <= w_last;
            end
        end else if (r_skid_vld && out_take) begin
            r_out <= r_skid;
        end
    end

    assign o_valid = r_out_vld;
    assign o_data  = r_out;

endmodule

`default_nettype wire

/* test/bend_twist_projection_check.sv */
`default_nettype none

module bend_twist_projection_check
    import bt_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    input  wire t_in_s       i_data,
    input  wire logic        o_stall,
    input  wire logic        o_valid,
    input  wire t_out_s      o_data,
    input  wire logic        i_stall,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    input  wire logic        pready,
    output int               o_fail_cnt,
    output int               o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef longint t_wide_quat [4];

    localparam longint ONE = 64'sd1 << 30;

    logic signed [31:0] rest_reg [8];
    t_out_s             proj_q [$];
    int                 fail_cnt;

    const string FIELD_NAME [8] = '{"proj_cur_w", "proj_cur_x", "proj_cur_y", "proj_cur_z",
        "proj_next_w", "proj_next_x", "proj_next_y", "proj_next_z"};

    assign o_fail_cnt = fail_cnt;
    assign o_pending  = proj_q.size();

    function automatic longint round_shift(input longint v, input int s);
        return (v + (64'sd1 << (s - 1))) >>> s;
    endfunction

    function automatic longint clamp32(input longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint fx_mul(input longint a, input longint b);
        return round_shift(a * b, 30);
    endfunction

    function automatic longint div_near(input longint num, input longint den);
        longint mag;
        longint quo;
        mag = (num < 0) ? -num : num;
        quo = (mag + den / 2) / den;
        return (num < 0) ? -quo : quo;
    endfunction

    function automatic t_wide_quat hamilton(input t_wide_quat a, input t_wide_quat b);
        t_wide_quat r;
        r[0] = clamp32(fx_mul(a[0], b[0]) - fx_mul(a[1], b[1])
                     - fx_mul(a[2], b[2]) - fx_mul(a[3], b[3]));
        r[1] = clamp32(fx_mul(a[0], b[1]) + fx_mul(a[1], b[0])
                     + fx_mul(a[2], b[3]) - fx_mul(a[3], b[2]));
        r[2] = clamp32(fx_mul(a[0], b[2]) - fx_mul(a[1], b[3])
                     + fx_mul(a[2], b[0]) + fx_mul(a[3], b[1]));
        r[3] = clamp32(fx_mul(a[0], b[3]) + fx_mul(a[1], b[2])
                     - fx_mul(a[2], b[1]) + fx_mul(a[3], b[0]));
        return r;
    endfunction

    function automatic t_wide_quat conjugate(input t_wide_quat a);
        t_wide_quat r;
        r[0] = a[0];
        for (int i = 1; i < 4; i++) r[i] = clamp32(-a[i]);
        return r;
    endfunction

    function automatic t_wide_quat invert(input t_wide_quat a);
        t_wide_quat r;
        longint n;
        n = 0;
        for (int i = 0; i < 4; i++) n += fx_mul(a[i], a[i]);
        if (n <= 0) begin
            r = '{0, 0, 0, 0};
            return r;
        end
        r[0] = clamp32(div_near(a[0] * ONE, n));
        for (int i = 1; i < 4; i++) r[i] = clamp32(div_near(-a[i] * ONE, n));
        return r;
    endfunction

    function automatic longint int_sqrt(input longint x);
        longint res;
        longint bit_v;
        res = 0;
        bit_v = 64'sd1 << 62;
        while (bit_v > x) bit_v = bit_v >>> 2;
        while (bit_v != 0) begin
            if (x >= res + bit_v) begin
                x = x - (res + bit_v);
                res = (res >>> 1) + bit_v;
            end else begin
                res = res >>> 1;
            end
            bit_v = bit_v >>> 2;
        end
        return res;
    endfunction

    function automatic t_wide_quat unit_scale(input t_wide_quat c);
        t_wide_quat r;
        longint s;
        longint root;
        s = 0;
        for (int i = 0; i < 4; i++) s += (c[i] * c[i]) >>> 2;
        root = int_sqrt(s);
        if (root == 0) return c;
        for (int i = 0; i < 4; i++) r[i] = clamp32(div_near(c[i] * (64'sd1 << 29), root));
        return r;
    endfunction

    function automatic t_out_s project_pair(input t_in_s d);
        t_wide_quat q, u, q0, u0, dar, idar, t, pre, w, qn, un;
        t_out_s res;
        q  = '{d.cur_w, d.cur_x, d.cur_y, d.cur_z};
        u  = '{d.next_w, d.next_x, d.next_y, d.next_z};
        q0 = '{rest_reg[0], rest_reg[1], rest_reg[2], rest_reg[3]};
        u0 = '{rest_reg[4], rest_reg[5], rest_reg[6], rest_reg[7]};
        dar  = hamilton(conjugate(q0), u0);
        idar = invert(dar);
        t    = hamilton(hamilton(idar, conjugate(q)), u);
        pre[0] = ONE;
        for (int i = 1; i < 4; i++) pre[i] = round_shift(t[i], 1);
        w  = unit_scale(pre);
        qn = unit_scale(hamilton(q, w));
        un = unit_scale(hamilton(u, conjugate(w)));
        res.proj_cur_w  = qn[0][31:0];
        res.proj_cur_x  = qn[1][31:0];
        res.proj_cur_y  = qn[2][31:0];
        res.proj_cur_z  = qn[3][31:0];
        res.proj_next_w = un[0][31:0];
        res.proj_next_x = un[1][31:0];
        res.proj_next_y = un[2][31:0];
        res.proj_next_z = un[3][31:0];
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t mismatch %s: got %h want %h", $time, what, got, want);
        fail_cnt++;
    endtask

    initial fail_cnt = 0;

    always @(posedge i_clk) begin
        t_out_s want;
        logic [255:0] got_bits;
        logic [255:0] want_bits;
        if (!i_rst_n) begin
            for (int i = 0; i < 8; i++)
                rest_reg[i] <= ((i == 0) || (i == 4)) ? Q30_ONE : '0;
            proj_q.delete();
        end else begin
            if (psel && penable && pwrite && pready && paddr[4:2] < 8)
                rest_reg[paddr[4:2]] <= pwdata;
            if (i_valid && !o_stall)
                proj_q.push_back(project_pair(i_data));
            if (o_valid && !i_stall) begin
                if (proj_q.size() == 0) begin
                    report_mismatch("unexpected result", o_data[255:224], '0);
                end else begin
                    want = proj_q.pop_front();
                    got_bits = o_data;
                    want_bits = want;
                    for (int k = 0; k < 8; k++)
                        if (got_bits[255-32*k -: 32] !== want_bits[255-32*k -: 32])
                            report_mismatch(FIELD_NAME[k], got_bits[255-32*k -: 32],
                                            want_bits[255-32*k -: 32]);
                end
            end
        end
    end
endmodule

`default_nettype wire

/* test/bend_twist_projection_test.sv */
`default_nettype none

module bend_twist_projection_test
    import bt_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    // no accept on any channel for this many cycles means the block hung
    localparam int HANG_LIMIT = 20000;
    // receiver hold-off length, well beyond the 145-stage pipe depth
    localparam int HOLD_CYCLES = 400;
    localparam int PHASE_ITEMS = 177;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    t_in_s       i_data;
    logic        o_stall;
    logic        o_valid;
    t_out_s      o_data;
    logic        i_stall;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    int          fail_cnt;
    int          pending;

    // stimulus-side knobs for the receiver and sender, request count and watchdog count
    bit          quiet;
    bit          hold_req;
    int          req_cnt;
    int          hang_cnt;

    bend_twist_projection u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_data  (i_data),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .o_data  (o_data),
        .i_stall (i_stall),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    bend_twist_projection_check u_check (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .i_data     (i_data),
        .o_stall    (o_stall),
        .o_valid    (o_valid),
        .o_data     (o_data),
        .i_stall    (i_stall),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .pready     (pready),
        .o_fail_cnt (fail_cnt),
        .o_pending  (pending)
    );

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    // Watchdog: counts cycles where no request, result or register access lands.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || (psel && penable))
            hang_cnt <= 0;
        else
            hang_cnt <= hang_cnt + 1;
        if (hang_cnt >= HANG_LIMIT) begin
            $display("timeout, %0d results outstanding", pending);
            $display("FAIL");
            $finish;
        end
    end

    // Receiver: random stall about a quarter of the time, none when quiet,
    // and a long solid hold-off on request so the pipe fills and backs up.
    initial begin
        i_stall = 1'b1;
        forever begin
            if (hold_req) begin
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end else begin
                i_stall <= quiet ? 1'b0 : ($urandom_range(99) < 25);
                @(posedge i_clk);
            end
        end
    end

    // One request; optional idle gap first. Returns right after the accept edge.
    task automatic send_request(input t_in_s d);
        if (!quiet && $urandom_range(99) < 25) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= d;
        do @(posedge i_clk); while (o_stall);
        req_cnt++;
    endtask

    // Setup and access cycle; the caller releases the bus after the last write.
    task automatic reg_write(input int idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 5'(idx * 4);
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
    endtask

    // Drain the pipe: sender goes idle until every result is back.
    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    // Component generator: mostly near-unit values, some raw 32-bit, some extremes.
    function automatic t_q30 rand_comp(input int mode);
        int pick;
        case (mode)
            0: begin
                return t_q30'(longint'($urandom_range(0, 32'h8000_0000)) - 64'sd1073741824);
            end
            1: begin
                return t_q30'($urandom);
            end
            default: begin
                pick = $urandom_range(3);
                case (pick)
                    0: return Q30_MIN;
                    1: return Q30_MAX;
                    2: return '0;
                    default: return t_q30'($urandom);
                endcase
            end
        endcase
    endfunction

    function automatic t_in_s rand_pair();
        t_in_s d;
        int mode;
        int r;
        r = $urandom_range(99);
        mode = (r < 65) ? 0 : (r < 90) ? 1 : 2;
        d = {rand_comp(mode), rand_comp(mode), rand_comp(mode), rand_comp(mode),
             rand_comp(mode), rand_comp(mode), rand_comp(mode), rand_comp(mode)};
        return d;
    endfunction

    task automatic set_rest(input logic [31:0] v [8]);
        drain();
        for (int i = 0; i < 8; i++) reg_write(i, v[i]);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic random_burst(input int n);
        for (int i = 0; i < n; i++) send_request(rand_pair());
    endtask

    initial begin
        logic [31:0] rest [8];
        t_in_s d;
        i_rst_n  = 1'b0;
        i_valid  = 1'b0;
        i_data   = '0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        quiet    = 1'b0;
        hold_req = 1'b0;
        req_cnt  = 0;
        hang_cnt = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed, with rest orientations at reset (identity).
        send_request({Q30_ONE, 32'sd0, 32'sd0, 32'sd0, Q30_ONE, 32'sd0, 32'sd0, 32'sd0});
        send_request('0);                         // zero vector: normalize passes through
        send_request({8{Q30_MIN}});               // -2.0 everywhere, conjugate saturates
        send_request({8{Q30_MAX}});
        send_request({Q30_MIN, Q30_MAX, Q30_MIN, Q30_MAX, Q30_MAX, Q30_MIN, Q30_MAX, Q30_MIN});
        send_request({32'sd0, Q30_ONE, 32'sd0, 32'sd0, 32'sd0, 32'sd0, Q30_ONE, 32'sd0});
        send_request({Q30_ONE, 32'sd0, 32'sd0, 32'sd0, -Q30_ONE, 32'sd0, 32'sd0, Q30_ONE});
        send_request({32'sd1, -32'sd1, 32'sd1, -32'sd1, 32'sd0, 32'sd0, 32'sd0, 32'sd1});
        for (int k = 0; k < 4; k++) begin
            d = {8{32'sd0}};
            d[255-32*k -: 32] = Q30_MIN;
            d[127-32*k -: 32] = Q30_MAX;
            send_request(d);
        end
        random_burst(PHASE_ITEMS - 12);

        // Random near-unit rest pose; the receiver holds off to back up the pipe.
        for (int i = 0; i < 8; i++) rest[i] = rand_comp(0);
        set_rest(rest);
        hold_req = 1'b1;
        random_burst(PHASE_ITEMS);

        // Zero rest pose: Darboux norm is zero, correction is identity.
        // No idling on either side through this phase.
        rest = '{default: '0};
        set_rest(rest);
        quiet = 1'b1;
        send_request({Q30_MIN, Q30_MAX, 32'sd0, Q30_ONE, Q30_MAX, Q30_MIN, Q30_ONE, 32'sd0});
        random_burst(PHASE_ITEMS);
        quiet = 1'b0;

        rest = '{default: Q30_MIN};
        set_rest(rest);
        random_burst(PHASE_ITEMS);

        rest = '{default: Q30_MAX};
        set_rest(rest);
        random_burst(PHASE_ITEMS);

        for (int i = 0; i < 8; i++) rest[i] = rand_comp(1);
        set_rest(rest);
        random_burst(PHASE_ITEMS);

        // Back near identity with a small random twist.
        rest = '{Q30_ONE, 32'($urandom_range(0, 1 << 24)), 0, 0,
                 Q30_ONE, 0, 32'($urandom_range(0, 1 << 24)), 0};
        set_rest(rest);
        random_burst(PHASE_ITEMS / 2);

        drain();
        repeat (300) @(posedge i_clk);
        $display("%0d requests over seven rest poses: identity, random, zero, all -2.0,", req_cnt);
        $display("all max, raw random and near identity; stalls, bursts and one long back-up");
        if (fail_cnt == 0 && pending == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule

`default_nettype wire
